FILE: src/sclp_pkg.sv
// Package for the sync / length / CRC16 frame parser.
// Holds the protocol constants, the result record and the CRC and counter helpers.
// No dependencies.
`default_nettype none

package sclp_pkg;

    // Protocol bytes and CRC settings.
    localparam logic [7:0]  SYNC_A     = 8'hAA;
    localparam logic [7:0]  SYNC_B     = 8'h55;
    localparam logic [7:0]  FOOT_A     = 8'h0D;
    localparam logic [7:0]  FOOT_B     = 8'h0A;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'h0000;

    // Kinds of result item.
    localparam logic ITEM_PAYLOAD   = 1'b0;
    localparam logic ITEM_FRAME_END = 1'b1;

    // One result item.
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  device_id;
        logic [7:0]  command_code;
        logic [15:0] payload_length;
        logic        crc_ok;
        logic        footer_ok;
        logic [31:0] frames_done;
        logic [31:0] crc_fail_count;
        logic [31:0] framing_error_count;
    } t_result;

    // One CRC16 update, MSB first, no reflection.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC after the sync pair, worked out at elaboration.
    localparam logic [15:0] CRC_AFTER_SYNC = crc_byte(crc_byte(CRC_INIT, SYNC_A), SYNC_B);

    // Saturating counter increment by a small amount.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] inc);
        logic [32:0] s;
        s = {1'b0, a} + {31'd0, inc};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/sclp_if.sv
// Channel interfaces for the frame parser: received bytes in, result items out.
// Depends on sclp_pkg for nothing but is compiled after it.
`default_nettype none

interface sclp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       flush;

    modport source (output valid, output rx_byte, output flush, input ready);
    modport sink   (input valid, input rx_byte, input flush, output ready);
endinterface

interface sclp_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  device_id;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
    logic        crc_ok;
    logic        footer_ok;
    logic [31:0] frames_done;
    logic [31:0] crc_fail_count;
    logic [31:0] framing_error_count;

    modport source (output valid, output item_kind, output payload_byte, output device_id,
                    output command_code, output payload_length, output crc_ok,
                    output footer_ok, output frames_done, output crc_fail_count,
                    output framing_error_count, input ready);
    modport sink   (input valid, input item_kind, input payload_byte, input device_id,
                    input command_code, input payload_length, input crc_ok,
                    input footer_ok, input frames_done, input crc_fail_count,
                    input framing_error_count, output ready);
endinterface

`default_nettype wire

FILE: src/sclp_core.sv
// Parse engine: phase machine, header capture, running CRC and error counters.
// Depends on sclp_pkg.
`default_nettype none

module sclp_core
    import sclp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_go,
    input  wire logic [7:0] i_byte,
    input  wire logic     i_flush,
    output logic          o_res_valid,
    output t_result       o_res
);

    typedef enum logic [3:0] {
        PH_HUNT_A, PH_HUNT_B, PH_DEV, PH_CMD, PH_LEN_LO, PH_LEN_HI,
        PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI, PH_FOOT_A, PH_FOOT_B
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [7:0]  r_device,   n_device;
    logic [7:0]  r_command,  n_command;
    logic [15:0] r_length,   n_length;
    logic [15:0] r_seen,     n_seen;
    logic [15:0] r_crc,      n_crc;
    logic [15:0] r_rx_crc,   n_rx_crc;
    logic        r_foot_a,   n_foot_a;
    logic [31:0] r_frames,   n_frames;
    logic [31:0] r_crc_err,  n_crc_err;
    logic [31:0] r_frm_err,  n_frm_err;

    logic [15:0] crc_upd;
    logic [15:0] seen_inc;
    logic        fok;
    logic        cok;

    assign crc_upd  = crc_byte(r_crc, i_byte);
    assign seen_inc = r_seen + 16'd1;
    assign fok      = r_foot_a && (i_byte == FOOT_B);
    assign cok      = (r_rx_crc == r_crc);

    // Next state and result for the byte being processed.
    always_comb begin
        n_phase   = r_phase;
        n_device  = r_device;
        n_command = r_command;
        n_length  = r_length;
        n_seen    = r_seen;
        n_crc     = r_crc;
        n_rx_crc  = r_rx_crc;
        n_foot_a  = r_foot_a;
        n_frames  = r_frames;
        n_crc_err = r_crc_err;
        n_frm_err = r_frm_err;
        o_res_valid = 1'b0;
        o_res.item_kind    = ITEM_PAYLOAD;
        o_res.payload_byte = 8'd0;
        o_res.crc_ok       = 1'b0;
        o_res.footer_ok    = 1'b0;

        if (i_flush) begin
            n_phase = PH_HUNT_A;
        end else begin
            case (r_phase)
                PH_HUNT_B: begin
                    if (i_byte == SYNC_B) begin
                        n_crc   = CRC_AFTER_SYNC;
                        n_phase = PH_DEV;
                    end else if (i_byte == SYNC_A) begin
                        n_frm_err = sat_add(r_frm_err, 2'd1);
                    end else begin
                        n_frm_err = sat_add(r_frm_err, 2'd2);
                        n_phase   = PH_HUNT_A;
                    end
                end
                PH_DEV: begin
                    n_device = i_byte;
                    n_crc    = crc_upd;
                    n_phase  = PH_CMD;
                end
                PH_CMD: begin
                    n_command = i_byte;
                    n_crc     = crc_upd;
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_length = {8'd0, i_byte};
                    n_crc    = crc_upd;
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_length = {i_byte, r_length[7:0]};
                    n_crc    = crc_upd;
                    n_seen   = 16'd0;
                    n_phase  = ({i_byte, r_length[7:0]} == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_crc  = crc_upd;
                    n_seen = seen_inc;
                    if (seen_inc == r_length) begin
                        n_phase = PH_CRC_LO;
                    end
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_byte;
                end
                PH_CRC_LO: begin
                    n_rx_crc = {8'd0, i_byte};
                    n_phase  = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    n_rx_crc = {i_byte, r_rx_crc[7:0]};
                    n_phase  = PH_FOOT_A;
                end
                PH_FOOT_A: begin
                    n_foot_a = (i_byte == FOOT_A);
                    n_phase  = PH_FOOT_B;
                end
                PH_FOOT_B: begin
                    if (!cok) begin
                        n_crc_err = sat_add(r_crc_err, 2'd1);
                    end
                    if (!fok) begin
                        n_frm_err = sat_add(r_frm_err, 2'd1);
                    end
                    n_frames           = sat_add(r_frames, 2'd1);
                    n_phase            = PH_HUNT_A;
                    o_res_valid        = 1'b1;
                    o_res.item_kind    = ITEM_FRAME_END;
                    o_res.crc_ok       = cok;
                    o_res.footer_ok    = fok;
                end
                default: begin
                    // Hunting for the first sync byte.
                    if (i_byte == SYNC_A) begin
                        n_phase = PH_HUNT_B;
                    end else begin
                        n_frm_err = sat_add(r_frm_err, 2'd1);
                        n_phase   = PH_HUNT_A;
                    end
                end
            endcase
        end

        // Header and counter fields show this byte's updated values.
        o_res.device_id           = r_device;
        o_res.command_code        = r_command;
        o_res.payload_length      = r_length;
        o_res.frames_done         = n_frames;
        o_res.crc_fail_count      = n_crc_err;
        o_res.framing_error_count = n_frm_err;
        o_res_valid               = o_res_valid && i_go;
    end

    // Parser state, updated only when a byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT_A;
            r_device  <= 8'd0;
            r_command <= 8'd0;
            r_length  <= 16'd0;
            r_seen    <= 16'd0;
            r_crc     <= CRC_INIT;
            r_rx_crc  <= 16'd0;
            r_foot_a  <= 1'b0;
            r_frames  <= 32'd0;
            r_crc_err <= 32'd0;
            r_frm_err <= 32'd0;
        end else if (i_go) begin
            r_phase   <= n_phase;
            r_device  <= n_device;
            r_command <= n_command;
            r_length  <= n_length;
            r_seen    <= n_seen;
            r_crc     <= n_crc;
            r_rx_crc  <= n_rx_crc;
            r_foot_a  <= n_foot_a;
            r_frames  <= n_frames;
            r_crc_err <= n_crc_err;
            r_frm_err <= n_frm_err;
        end
    end

endmodule

`default_nettype wire

FILE: src/sclp_out_buf.sv
// Two-entry result register that parts the parse engine from the output channel.
// Depends on sclp_pkg for the result record.
`default_nettype none

module sclp_out_buf
    import sclp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_result   i_data,
    output logic      o_space,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    // Space is judged from the stored count alone, so no ready path runs through.
    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/sync_length_crc16_frame_parser_top.sv
// Top level of the sync / length / CRC16 frame parser.
// Holds the input register; uses sclp_pkg, sclp_if, sclp_core and sclp_out_buf.
//
// Usage:
//   i_in carries received bytes (rx_byte) with a flush flag; a transfer with
//   flush set drops any partial frame and restarts the sync hunt.
//   o_out carries one result item per payload byte and one frame-end item
//   after the footer, each with the frame header and the three saturating
//   counters as they stand after that byte.
// Timing:
//   One byte per cycle sustained while the result buffer has room. A byte
//   is held in the input register, where the phase step and the one-byte CRC
//   update run, and its result is written into the result buffer, which drives o_out.
//   Header, sync, CRC and first footer bytes produce no item, nor do flush transfers.
// Reset:
//   Synchronous active-low reset returns to the sync hunt and clears all
//   counters; no item is pending afterwards.
// Stalls:
//   A two-entry result buffer absorbs one extra item; while it is full the
//   input register holds its byte and i_in.ready falls. No item is dropped.
`default_nettype none

module sync_length_crc16_frame_parser_top
    import sclp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sclp_in_if.sink    i_in,
    sclp_out_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_flush;
    logic       proc_go;
    logic       buf_space;
    logic       res_valid;
    t_result    res;
    t_result    out_data;

    // The held byte is processed whenever the result buffer has room.
    assign proc_go    = r_in_valid && buf_space;
    assign i_in.ready = !r_in_valid || proc_go;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.rx_byte;
            r_in_flush <= i_in.flush;
        end
    end

    sclp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (proc_go),
        .i_byte      (r_in_byte),
        .i_flush     (r_in_flush),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sclp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (buf_space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (out_data)
    );

    // Result fields onto the output channel.
    assign o_out.item_kind           = out_data.item_kind;
    assign o_out.payload_byte        = out_data.payload_byte;
    assign o_out.device_id           = out_data.device_id;
    assign o_out.command_code        = out_data.command_code;
    assign o_out.payload_length      = out_data.payload_length;
    assign o_out.crc_ok              = out_data.crc_ok;
    assign o_out.footer_ok           = out_data.footer_ok;
    assign o_out.frames_done         = out_data.frames_done;
    assign o_out.crc_fail_count      = out_data.crc_fail_count;
    assign o_out.framing_error_count = out_data.framing_error_count;

endmodule

`default_nettype wire
